// ===== hdl/owt_pkg.sv =====
package owt_pkg;

   typedef enum logic [4:0] {
      KIND_LBRACE   = 5'd0,
      KIND_RBRACE   = 5'd1,
      KIND_LPAREN   = 5'd2,
      KIND_RPAREN   = 5'd3,
      KIND_GT       = 5'd4,
      KIND_GE       = 5'd5,
      KIND_LT       = 5'd6,
      KIND_LE       = 5'd7,
      KIND_ASSIGN   = 5'd8,
      KIND_EQ       = 5'd9,
      KIND_NOT      = 5'd10,
      KIND_NE       = 5'd11,
      KIND_PLUS     = 5'd12,
      KIND_MINUS    = 5'd13,
      KIND_STAR     = 5'd14,
      KIND_SLASH    = 5'd15,
      KIND_PERCENT  = 5'd16,
      KIND_SEMI     = 5'd17,
      KIND_AND      = 5'd18,
      KIND_OR       = 5'd19,
      KIND_WORDCHAR = 5'd20,
      KIND_WORDEND  = 5'd21,
      KIND_END      = 5'd22,
      KIND_ERROR    = 5'd23
   } token_kind_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
   } owt_req_type;

   typedef struct packed {
      logic [4:0] token_kind;
      logic [7:0] char_value;
      logic       last;
   } owt_rsp_type;

   typedef struct packed {
      logic [1:0]  count;
      owt_rsp_type r0;
      owt_rsp_type r1;
   } owt_set_type;

endpackage

// ===== hdl/owt_lexer.sv =====
module owt_lexer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  owt_pkg::owt_req_type item,
   output owt_pkg::owt_set_type results
);
   import owt_pkg::*;

   typedef enum logic [2:0] {
      PEND_NONE = 3'd0,
      PEND_GT   = 3'd1,
      PEND_LT   = 3'd2,
      PEND_EQ   = 3'd3,
      PEND_BANG = 3'd4,
      PEND_AMP  = 3'd5,
      PEND_BAR  = 3'd6
   } pend_type;

   typedef struct packed {
      pend_type    pend;
      logic        in_word;
      logic        err;
      owt_set_type set;
   } work_type;

   localparam logic [7:0] CH_EQ  = 8'h3D;
   localparam logic [7:0] CH_AMP = 8'h26;
   localparam logic [7:0] CH_BAR = 8'h7C;
   localparam logic [7:0] CH_NUL = 8'h00;

   pend_type pend_ff, pend_in;
   logic     in_word_ff, in_word_in;
   logic     err_hold_ff, err_hold_in;
   work_type w;

   function automatic logic is_alnum(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_simple(logic [7:0] c);
      return (c == 8'h7B) || (c == 8'h7D) || (c == 8'h28) || (c == 8'h29) ||
             (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
             (c == 8'h25) || (c == 8'h3B);
   endfunction

   function automatic token_kind_type simple_kind(logic [7:0] c);
      case (c)
         8'h7B:   return KIND_LBRACE;
         8'h7D:   return KIND_RBRACE;
         8'h28:   return KIND_LPAREN;
         8'h29:   return KIND_RPAREN;
         8'h2B:   return KIND_PLUS;
         8'h2D:   return KIND_MINUS;
         8'h2A:   return KIND_STAR;
         8'h2F:   return KIND_SLASH;
         8'h25:   return KIND_PERCENT;
         8'h3B:   return KIND_SEMI;
         default: return KIND_ERROR;
      endcase
   endfunction

   function automatic pend_type pend_code(logic [7:0] c);
      case (c)
         8'h3E:   return PEND_GT;
         8'h3C:   return PEND_LT;
         CH_EQ:   return PEND_EQ;
         8'h21:   return PEND_BANG;
         CH_AMP:  return PEND_AMP;
         CH_BAR:  return PEND_BAR;
         default: return PEND_NONE;
      endcase
   endfunction

   function automatic token_kind_type combined_kind(pend_type p);
      case (p)
         PEND_GT:   return KIND_GE;
         PEND_LT:   return KIND_LE;
         PEND_EQ:   return KIND_EQ;
         PEND_BANG: return KIND_NE;
         default:   return KIND_ERROR;
      endcase
   endfunction

   function automatic work_type emit(work_type wi, token_kind_type k, logic [7:0] cv);
      work_type    wo;
      owt_rsp_type r;
      wo           = wi;
      r.token_kind = k;
      r.char_value = cv;
      r.last       = 1'b0;
      if (wo.set.count == 2'd0) begin
         wo.set.r0 = r;
      end else if (wo.set.count == 2'd1) begin
         wo.set.r1 = r;
      end
      if (wo.set.count != 2'd2) begin
         wo.set.count = wo.set.count + 2'd1;
      end
      return wo;
   endfunction

   function automatic work_type flush(work_type wi);
      work_type wo;
      pend_type p;
      wo      = wi;
      p       = wi.pend;
      wo.pend = PEND_NONE;
      case (p)
         PEND_GT:   wo = emit(wo, KIND_GT, CH_NUL);
         PEND_LT:   wo = emit(wo, KIND_LT, CH_NUL);
         PEND_EQ:   wo = emit(wo, KIND_ASSIGN, CH_NUL);
         PEND_BANG: wo = emit(wo, KIND_NOT, CH_NUL);
         PEND_AMP: begin
            wo     = emit(wo, KIND_ERROR, CH_AMP);
            wo.err = 1'b1;
         end
         PEND_BAR: begin
            wo     = emit(wo, KIND_ERROR, CH_BAR);
            wo.err = 1'b1;
         end
         default: wo.pend = PEND_NONE;
      endcase
      return wo;
   endfunction

   function automatic work_type take_byte(work_type wi, logic [7:0] c);
      work_type wo;
      wo = wi;
      if (wo.in_word && !is_alnum(c)) begin
         wo         = emit(wo, KIND_WORDEND, CH_NUL);
         wo.in_word = 1'b0;
      end
      if (!is_space(c)) begin
         priority if (is_simple(c)) begin
            wo = emit(wo, simple_kind(c), CH_NUL);
         end else if (pend_code(c) != PEND_NONE) begin
            wo.pend = pend_code(c);
         end else if (is_alnum(c)) begin
            wo         = emit(wo, KIND_WORDCHAR, c);
            wo.in_word = 1'b1;
         end else begin
            wo     = emit(wo, KIND_ERROR, c);
            wo.err = 1'b1;
         end
      end
      return wo;
   endfunction

   always_comb begin
      w.pend    = pend_ff;
      w.in_word = in_word_ff;
      w.err     = err_hold_ff;
      w.set     = '0;
      if (take) begin
         if (item.is_end) begin
            if (!w.err) begin
               if (w.pend != PEND_NONE) begin
                  w = flush(w);
               end else if (w.in_word) begin
                  w = emit(w, KIND_WORDEND, CH_NUL);
               end
            end
            w         = emit(w, KIND_END, CH_NUL);
            w.pend    = PEND_NONE;
            w.in_word = 1'b0;
            w.err     = 1'b0;
         end else if (!w.err) begin
            if (w.pend != PEND_NONE) begin
               priority if ((w.pend == PEND_GT || w.pend == PEND_LT || w.pend == PEND_EQ ||
                             w.pend == PEND_BANG) && item.ch == CH_EQ) begin
                  w      = emit(w, combined_kind(w.pend), CH_NUL);
                  w.pend = PEND_NONE;
               end else if (w.pend == PEND_AMP && item.ch == CH_AMP) begin
                  w      = emit(w, KIND_AND, CH_NUL);
                  w.pend = PEND_NONE;
               end else if (w.pend == PEND_BAR && item.ch == CH_BAR) begin
                  w      = emit(w, KIND_OR, CH_NUL);
                  w.pend = PEND_NONE;
               end else begin
                  w = flush(w);
                  if (!w.err) begin
                     w = take_byte(w, item.ch);
                  end
               end
            end else begin
               w = take_byte(w, item.ch);
            end
         end
         if (w.set.count == 2'd1) begin
            w.set.r0.last = 1'b1;
         end else if (w.set.count == 2'd2) begin
            w.set.r1.last = 1'b1;
         end
      end
   end

   assign pend_in     = w.pend;
   assign in_word_in  = w.in_word;
   assign err_hold_in = w.err;
   assign results     = w.set;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= PEND_NONE;
         in_word_ff  <= 1'b0;
         err_hold_ff <= 1'b0;
      end else begin
         pend_ff     <= pend_in;
         in_word_ff  <= in_word_in;
         err_hold_ff <= err_hold_in;
      end
   end

endmodule

// ===== hdl/operator_word_tokenizer_top.sv =====
// Streaming tokenizer: one source byte, or an end marker, is taken per transfer and
// turned into zero, one or two token results, with one character of lookahead for
// the two-character operators. The block takes one item per cycle. Results wait in
// a two-entry output queue, and a new item is taken only when that queue will be
// empty at the clock edge, so an item that yields two results, or a stalled result
// side, holds the input until the queue has drained.
module operator_word_tokenizer_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  owt_pkg::owt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output owt_pkg::owt_rsp_type rsp_data
);
   import owt_pkg::*;

   logic [1:0]  count_ff, count_in;
   owt_rsp_type slot0_ff, slot0_in;
   owt_rsp_type slot1_ff, slot1_in;
   logic        req_take;
   logic        rsp_take;
   owt_set_type lex_set;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = !((count_ff == 2'd0) || (count_ff == 2'd1 && rsp_take));
   assign req_take  = req_valid && !req_stall;
   assign rsp_data  = slot0_ff;

   owt_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .take    (req_take),
      .item    (req_data),
      .results (lex_set)
   );

   always_comb begin
      if (req_take) begin
         count_in = lex_set.count;
         slot0_in = lex_set.r0;
         slot1_in = lex_set.r1;
      end else if (rsp_take) begin
         count_in = count_ff - 2'd1;
         slot0_in = slot1_ff;
         slot1_in = slot1_ff;
      end else begin
         count_in = count_ff;
         slot0_in = slot0_ff;
         slot1_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== hdl/owt_checker.sv =====
module owt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input owt_pkg::owt_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input owt_pkg::owt_rsp_type rsp_data
);
   import owt_pkg::*;

   logic unused_req;
   assign unused_req = req_valid ^ req_stall ^ (^req_data);

   // The first result of a pair is always followed by the second one.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("second result of a pair missing");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind == KIND_END |-> rsp_data.last)
      else $error("end token not the last result of its item");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.token_kind <= KIND_ERROR)
      else $error("token kind out of range");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind != KIND_WORDCHAR &&
      rsp_data.token_kind != KIND_ERROR |-> rsp_data.char_value == 8'h00)
      else $error("character value set on a plain token");

endmodule

bind operator_word_tokenizer_top owt_checker u_owt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
